// ===== hdl/yrgb_pkg.sv =====
// shared types, constants and arithmetic helpers for the yuyv to rgb24 converter
// no dependencies; used by every module in hdl/
package yrgb_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [7:0] COEF_RV = 8'd140;
  localparam logic [7:0] COEF_GU = 8'd34;
  localparam logic [7:0] COEF_GV = 8'd71;
  localparam logic [7:0] COEF_BU = 8'd177;

  // reciprocal of 100, exact for numerators below 43690
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             frame_end;
  } pos_t;

  function automatic logic [7:0] div100(input logic [14:0] n);
    logic [27:0] p;
    p = {13'd0, n} * {15'd0, RECIP_100};
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  // (coef * (c - 128)) / 100, truncated toward zero
  function automatic logic signed [8:0] chroma_term(input logic [7:0] coef,
                                                    input logic [7:0] c);
    logic       neg;
    logic [7:0] mag;
    logic [15:0] prod;
    logic [7:0] q;
    neg  = ~c[7];
    mag  = neg ? (8'd128 - c) : (c - 8'd128);
    prod = {8'd0, coef} * {8'd0, mag};
    q    = div100(prod[14:0]);
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/yuyv_to_rgb24_bottom_up.sv =====
// top level of the yuyv 4:2:2 to rgb24 converter with bottom-up addressing
// depends on yrgb_pkg, yrgb_color, yrgb_pos
//
// usage:
//   input channel (in_valid/in_ready) takes one packed yuyv word: luma_first,
//   chroma_blue, luma_second, chroma_red. output channel (out_valid/out_ready)
//   gives one rgb pixel per word transfer, the luma_first pixel first, with its
//   bottom-up destination row and column, last_of_pair and frame_end.
//   config channel (cfg_valid/cfg_ready) writes frame_width (index 0) or
//   frame_height (index 1); it is always ready, write only while idle.
// timing:
//   an input word is held in a word register; each pixel goes through the
//   color logic into the output register, the luma_first pixel first and the
//   luma_second pixel next, each as soon as the output register can take it.
//   the single output port moves one pixel a cycle while out_ready is high;
//   a new word is taken in the cycle its predecessor's second pixel enters
//   the output register.
// reset:
//   clears both buffers and the row/column counters, width back to 640 and
//   height back to 480. when out_ready is low the output register holds its
//   pixel, the word register holds its word and in_ready is low while it is full.
module yuyv_to_rgb24_bottom_up (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      luma_first,
  input  logic [7:0]                      chroma_blue,
  input  logic [7:0]                      luma_second,
  input  logic [7:0]                      chroma_red,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      blue,
  output logic [7:0]                      green,
  output logic [7:0]                      red,
  output logic [yrgb_pkg::POS_W-1:0]      dest_row,
  output logic [yrgb_pkg::POS_W-1:0]      dest_column,
  output logic                            last_of_pair,
  output logic                            frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [yrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yrgb_pkg::DIM_W-1:0]      cfg_data
);

  logic       full;
  logic       phase;
  logic [7:0] y0;
  logic [7:0] y1;
  logic [7:0] u;
  logic [7:0] v;
  logic       accept;
  logic       load;
  logic [7:0] luma_sel;

  yrgb_pkg::rgb_t rgb;
  yrgb_pkg::pos_t pos;

  assign cfg_ready = 1'b1;
  assign load      = full && (!out_valid || out_ready);
  assign in_ready  = !full || (phase && load);
  assign accept    = in_valid && in_ready;
  assign luma_sel  = phase ? y1 : y0;

  yrgb_color u_color (
    .luma        (luma_sel),
    .chroma_blue (u),
    .chroma_red  (v),
    .rgb         (rgb)
  );

  yrgb_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (load),
    .pos       (pos)
  );

  // word register
  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (load) begin
        phase <= !phase;
      end
      if (accept) begin
        full <= 1'b1;
      end else if (load && phase) begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y0 <= luma_first;
      y1 <= luma_second;
      u  <= chroma_blue;
      v  <= chroma_red;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blue         <= rgb.blue;
      green        <= rgb.green;
      red          <= rgb.red;
      dest_row     <= pos.row;
      dest_column  <= pos.column;
      last_of_pair <= phase;
      frame_end    <= pos.frame_end;
    end
  end

endmodule

// ===== hdl/yrgb_color.sv =====
// color math for one pixel: luma plus scaled chroma terms (minus for green), clamped to a byte
// depends on yrgb_pkg
module yrgb_color (
  input  logic [7:0]    luma,
  input  logic [7:0]    chroma_blue,
  input  logic [7:0]    chroma_red,
  output yrgb_pkg::rgb_t rgb
);

  logic signed [8:0]  rterm;
  logic signed [8:0]  bterm;
  logic signed [8:0]  gterm_u;
  logic signed [8:0]  gterm_v;
  logic signed [10:0] gterm;
  logic signed [10:0] y;

  always_comb begin
    rterm   = yrgb_pkg::chroma_term(yrgb_pkg::COEF_RV, chroma_red);
    bterm   = yrgb_pkg::chroma_term(yrgb_pkg::COEF_BU, chroma_blue);
    gterm_u = yrgb_pkg::chroma_term(yrgb_pkg::COEF_GU, chroma_blue);
    gterm_v = yrgb_pkg::chroma_term(yrgb_pkg::COEF_GV, chroma_red);
    gterm   = 11'(gterm_u) + 11'(gterm_v);
    y       = $signed({3'd0, luma});
    rgb.blue  = yrgb_pkg::clamp_byte(y + 11'(bterm));
    rgb.green = yrgb_pkg::clamp_byte(y - gterm);
    rgb.red   = yrgb_pkg::clamp_byte(y + 11'(rterm));
  end

endmodule

// ===== hdl/yrgb_pos.sv =====
// frame geometry registers and bottom-up row/column counters
// depends on yrgb_pkg
module yrgb_pos (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [yrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yrgb_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            advance,
  output yrgb_pkg::pos_t                  pos
);

  logic [yrgb_pkg::DIM_W-1:0] frame_width;
  logic [yrgb_pkg::DIM_W-1:0] frame_height;
  logic [yrgb_pkg::POS_W-1:0] column_count;
  logic [yrgb_pkg::POS_W-1:0] line_count;
  logic [yrgb_pkg::POS_W-1:0] column_count_next;
  logic [yrgb_pkg::POS_W-1:0] line_count_next;

  logic [yrgb_pkg::DIM_W-1:0] w_eff;
  logic [yrgb_pkg::DIM_W-1:0] h_eff;
  logic [yrgb_pkg::DIM_W-1:0] w_m1;
  logic [yrgb_pkg::DIM_W-1:0] h_m1;
  logic [yrgb_pkg::POS_W-1:0] last_col;
  logic [yrgb_pkg::POS_W-1:0] last_line;
  logic [yrgb_pkg::POS_W-1:0] col_eff;
  logic [yrgb_pkg::POS_W-1:0] line_eff;
  logic                       end_col;
  logic                       end_line;

  always_comb begin
    w_eff     = yrgb_pkg::eff_dim(frame_width);
    h_eff     = yrgb_pkg::eff_dim(frame_height);
    w_m1      = w_eff - yrgb_pkg::DIM_W'(1);
    h_m1      = h_eff - yrgb_pkg::DIM_W'(1);
    last_col  = w_m1[yrgb_pkg::POS_W-1:0];
    last_line = h_m1[yrgb_pkg::POS_W-1:0];
    col_eff   = (column_count > last_col) ? last_col : column_count;
    line_eff  = (line_count > last_line) ? last_line : line_count;
    end_col   = (col_eff == last_col);
    end_line  = (line_eff == last_line);

    pos.row       = last_line - line_eff;
    pos.column    = col_eff;
    pos.frame_end = end_col && end_line;

    // clamped positions are stored back so a later grow does not revive them
    if (end_col) begin
      column_count_next = '0;
      line_count_next   = end_line ? '0 : line_eff + yrgb_pkg::POS_W'(1);
    end else begin
      column_count_next = col_eff + yrgb_pkg::POS_W'(1);
      line_count_next   = line_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= yrgb_pkg::WIDTH_RESET;
      frame_height <= yrgb_pkg::HEIGHT_RESET;
      column_count <= '0;
      line_count   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (yrgb_pkg::cfg_reg_t'(cfg_index))
          yrgb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          yrgb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        column_count <= column_count_next;
        line_count   <= line_count_next;
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for yuyv_to_rgb24_bottom_up: directed words and frame sizes, then random
// words, random idling on input and output, every pixel checked by a behavioral predictor
// depends on yrgb_pkg and the converter rtl
module tb;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_word_t;

  typedef struct {
    logic [7:0]                 blue;
    logic [7:0]                 green;
    logic [7:0]                 red;
    logic [yrgb_pkg::POS_W-1:0] row;
    logic [yrgb_pkg::POS_W-1:0] column;
    logic                       second;
    logic                       fend;
  } pixel_t;

  typedef struct {
    bit                         is_write;
    yrgb_pkg::cfg_reg_t         reg_sel;
    logic [yrgb_pkg::DIM_W-1:0] reg_val;
    yuyv_word_t                 word;
    bit                         typed;
    yrgb_pkg::rgb_t             first_rgb;
    yrgb_pkg::rgb_t             second_rgb;
  } directed_step_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       luma_first = '0;
  logic [7:0]       chroma_blue = '0;
  logic [7:0]       luma_second = '0;
  logic [7:0]       chroma_red = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       blue;
  logic [7:0]       green;
  logic [7:0]       red;
  logic [yrgb_pkg::POS_W-1:0] dest_row;
  logic [yrgb_pkg::POS_W-1:0] dest_column;
  logic             last_of_pair;
  logic             frame_end;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [yrgb_pkg::CFG_IDX_W-1:0] cfg_index = yrgb_pkg::REG_FRAME_WIDTH;
  logic [yrgb_pkg::DIM_W-1:0] cfg_data = '0;

  logic [yrgb_pkg::DIM_W-1:0] width_setting = yrgb_pkg::WIDTH_RESET;
  logic [yrgb_pkg::DIM_W-1:0] height_setting = yrgb_pkg::HEIGHT_RESET;
  int               column_pos = 0;
  int               line_pos = 0;
  pixel_t           pending_pixels[$];
  pixel_t           head_px;
  int               errors = 0;
  int               words_sent = 0;
  int               pixels_checked = 0;
  int               frame_ends = 0;
  int               reg_writes = 0;
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;

  yuyv_to_rgb24_bottom_up uut (.*);

  always #2 clk = ~clk;

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic int dim_used(input logic [yrgb_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > yrgb_pkg::MAX_DIM) return yrgb_pkg::MAX_DIM;
    return int'(v);
  endfunction

  // two pixels per word, y0 pixel first, positions in bottom-up order
  function automatic void convert_word(input yuyv_word_t w, input bit typed,
                                       input yrgb_pkg::rgb_t first_rgb,
                                       input yrgb_pkg::rgb_t second_rgb);
    int     u_off, v_off, r_term, g_term, b_term, y, wd, ht, k;
    pixel_t px;
    u_off  = int'(w.chroma_blue) - 128;
    v_off  = int'(w.chroma_red) - 128;
    r_term = (140 * v_off) / 100;
    g_term = (34 * u_off) / 100 + (71 * v_off) / 100;
    b_term = (177 * u_off) / 100;
    wd = dim_used(width_setting);
    ht = dim_used(height_setting);
    for (k = 0; k < 2; k++) begin
      y = (k == 0) ? int'(w.luma_first) : int'(w.luma_second);
      if (column_pos > wd - 1) column_pos = wd - 1;
      if (line_pos > ht - 1) line_pos = ht - 1;
      px.blue  = sat8(y + b_term);
      px.green = sat8(y - g_term);
      px.red   = sat8(y + r_term);
      if (typed) begin
        {px.blue, px.green, px.red} = (k == 0) ? first_rgb : second_rgb;
      end
      px.row    = yrgb_pkg::POS_W'(ht - 1 - line_pos);
      px.column = yrgb_pkg::POS_W'(column_pos);
      px.second = (k == 1);
      px.fend   = 1'b0;
      if (column_pos + 1 >= wd) begin
        column_pos = 0;
        if (line_pos + 1 >= ht) begin
          line_pos = 0;
          px.fend  = 1'b1;
        end else begin
          line_pos++;
        end
      end else begin
        column_pos++;
      end
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic directed_step_t word_step(input logic [7:0] y0, u, y1, v);
    directed_step_t s;
    s.is_write   = 1'b0;
    s.reg_sel    = yrgb_pkg::REG_FRAME_WIDTH;
    s.reg_val    = '0;
    s.word       = {y0, u, y1, v};
    s.typed      = 1'b0;
    s.first_rgb  = '0;
    s.second_rgb = '0;
    return s;
  endfunction

  // neutral chroma: every color equals its luma
  function automatic directed_step_t gray_step(input logic [7:0] y0, y1);
    directed_step_t s;
    s            = word_step(y0, 8'd128, y1, 8'd128);
    s.typed      = 1'b1;
    s.first_rgb  = {y0, y0, y0};
    s.second_rgb = {y1, y1, y1};
    return s;
  endfunction

  function automatic directed_step_t write_step(input yrgb_pkg::cfg_reg_t sel,
                                                input logic [yrgb_pkg::DIM_W-1:0] val);
    directed_step_t s;
    s          = word_step(8'd0, 8'd0, 8'd0, 8'd0);
    s.is_write = 1'b1;
    s.reg_sel  = sel;
    s.reg_val  = val;
    return s;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'd127;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name,
                                      input logic [yrgb_pkg::POS_W-1:0] want,
                                      input logic [yrgb_pkg::POS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_word(input yuyv_word_t w, input bit typed,
                           input yrgb_pkg::rgb_t first_rgb,
                           input yrgb_pkg::rgb_t second_rgb);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {luma_first, chroma_blue, luma_second, chroma_red} <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    convert_word(w, typed, first_rgb, second_rgb);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input yrgb_pkg::cfg_reg_t sel,
                           input logic [yrgb_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (sel == yrgb_pkg::REG_FRAME_WIDTH) begin
      width_setting = val;
    end else begin
      height_setting = val;
    end
    reg_writes++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing expected: row %0d column %0d", dest_row, dest_column);
        errors++;
      end else begin
        head_px = pending_pixels.pop_front();
        check_field("blue", yrgb_pkg::POS_W'(head_px.blue), yrgb_pkg::POS_W'(blue));
        check_field("green", yrgb_pkg::POS_W'(head_px.green), yrgb_pkg::POS_W'(green));
        check_field("red", yrgb_pkg::POS_W'(head_px.red), yrgb_pkg::POS_W'(red));
        check_field("dest_row", head_px.row, dest_row);
        check_field("dest_column", head_px.column, dest_column);
        check_field("last_of_pair", yrgb_pkg::POS_W'(head_px.second),
                    yrgb_pkg::POS_W'(last_of_pair));
        check_field("frame_end", yrgb_pkg::POS_W'(head_px.fend),
                    yrgb_pkg::POS_W'(frame_end));
        pixels_checked++;
        if (head_px.fend) frame_ends++;
      end
    end
  end

  // output side: random stalls per pixel, with stretches of none
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 47) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    directed_step_t             steps[$];
    yuyv_word_t                 w;
    logic [yrgb_pkg::DIM_W-1:0] pw, ph;
    int                         phase, n;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    steps.push_back(gray_step(8'd0, 8'd255));
    steps.push_back(gray_step(8'd255, 8'd0));
    steps.push_back(gray_step(8'd1, 8'd128));
    steps.push_back(word_step(8'd255, 8'd0, 8'd0, 8'd255));
    steps.push_back(word_step(8'd0, 8'd255, 8'd255, 8'd0));
    steps.push_back(word_step(8'd255, 8'd255, 8'd0, 8'd255));
    steps.push_back(word_step(8'd0, 8'd0, 8'd255, 8'd0));
    // small and extreme chroma offsets, truncation toward zero
    steps.push_back(word_step(8'd128, 8'd127, 8'd128, 8'd129));
    steps.push_back(word_step(8'd16, 8'd125, 8'd235, 8'd131));
    steps.push_back(word_step(8'd200, 8'd1, 8'd50, 8'd254));
    // column already past the new width
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_WIDTH, 13'd3));
    steps.push_back(word_step(8'd10, 8'd200, 8'd20, 8'd60));
    steps.push_back(word_step(8'd90, 8'd30, 8'd170, 8'd220));
    steps.push_back(word_step(8'd170, 8'd85, 8'd85, 8'd170));
    steps.push_back(word_step(8'd240, 8'd16, 8'd16, 8'd240));
    // line already past the new height, then frame wrap
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_HEIGHT, 13'd2));
    steps.push_back(word_step(8'd60, 8'd110, 8'd70, 8'd150));
    steps.push_back(word_step(8'd33, 8'd66, 8'd99, 8'd132));
    steps.push_back(word_step(8'd180, 8'd190, 8'd200, 8'd210));
    // zero sizes act as one: every pixel ends a frame
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_WIDTH, 13'd0));
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_HEIGHT, 13'd0));
    steps.push_back(word_step(8'd5, 8'd250, 8'd250, 8'd5));
    steps.push_back(word_step(8'd128, 8'd128, 8'd127, 8'd127));
    // oversize acts as 4096, top row 4095
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_WIDTH, 13'd8191));
    steps.push_back(write_step(yrgb_pkg::REG_FRAME_HEIGHT, 13'd8191));
    steps.push_back(word_step(8'd77, 8'd144, 8'd211, 8'd99));
    steps.push_back(word_step(8'd255, 8'd128, 8'd0, 8'd128));

    foreach (steps[i]) begin
      if (steps[i].is_write) begin
        wait_idle();
        write_reg(steps[i].reg_sel, steps[i].reg_val);
      end else begin
        send_word(steps[i].word, steps[i].typed, steps[i].first_rgb, steps[i].second_rgb);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin pw = 13'd1; ph = 13'd1; end
        1: begin pw = 13'd2; ph = 13'd3; end
        2: begin pw = 13'd7; ph = 13'd2; end
        3: begin pw = 13'd5; ph = 13'd0; end
        4: begin pw = 13'd4096; ph = 13'd4097; end
        5: begin pw = 13'd3; ph = 13'd4; end
        6: begin
          pw = yrgb_pkg::DIM_W'($urandom_range(1, 12));
          ph = yrgb_pkg::DIM_W'($urandom_range(1, 6));
        end
        default: begin pw = yrgb_pkg::WIDTH_RESET; ph = yrgb_pkg::HEIGHT_RESET; end
      endcase
      wait_idle();
      write_reg(yrgb_pkg::REG_FRAME_WIDTH, pw);
      write_reg(yrgb_pkg::REG_FRAME_HEIGHT, ph);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 75; n++) begin
        // hold off until the output side has caught up
        if (n == 37 && phase % 2 == 0) wait_idle();
        if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
        w = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_word(w, 1'b0, '0, '0);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);

    $display("tb: %0d words in, %0d pixels checked, %0d frame ends, %0d register writes",
             words_sent, pixels_checked, frame_ends, reg_writes);
    $display("tb: sizes from 1x1 to 4096x4096, shrunk counters, chroma extremes, random stalls");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
